/* sv/psseq_pkg.sv */
// Package for the power state sequencer: item structs, mode and action codes,
// configuration register indexes and reset values. Used by every module of the block.
package psseq_pkg;

  // Width of one configuration write.
  localparam int unsigned CfgDataWidth = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_SLEEP_DUTY   = 2'd0;
  localparam logic [1:0] CFG_FLOOR_DUTY       = 2'd1;
  localparam logic [1:0] CFG_FEEDBACK_HOLD_MS = 2'd2;
  localparam logic [1:0] CFG_FADE_PRESCALE    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  MAX_SLEEP_DUTY_RST   = 8'd100;
  localparam logic [7:0]  FLOOR_DUTY_RST       = 8'd5;
  localparam logic [15:0] FEEDBACK_HOLD_MS_RST = 16'd3000;
  localparam logic [7:0]  FADE_PRESCALE_RST    = 8'd8;

  // Duty of a fully lit LED.
  localparam logic [7:0] FULL_DUTY = 8'd255;

  typedef enum logic [1:0] {
    KIND_BUTTON = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_ACTIVE     = 3'd0,
    MODE_SLEEP      = 3'd1,
    MODE_SLEEP_CHRG = 3'd2,
    MODE_SHUTDOWN   = 3'd3,
    MODE_FEEDBACK   = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_SLEEP      = 4'd1,
    ACT_WAKE       = 4'd2,
    ACT_CHRG_SLEEP = 4'd3,
    ACT_SD_WAKE    = 4'd4,
    ACT_FB_START   = 4'd5,
    ACT_FB_END     = 4'd6,
    ACT_CHRG_IND   = 4'd7,
    ACT_LOWBAT_IND = 4'd8
  } action_e;

  typedef struct packed {
    logic [7:0]  max_sleep_duty;
    logic [7:0]  floor_duty;
    logic [15:0] feedback_hold_ms;
    logic [7:0]  fade_prescale;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        button_level;
    logic        switch_off;
    logic [6:0]  charge_percent;
    logic        charging;
    logic        bms_ok;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] power_mode;
    logic [3:0] action;
    logic [7:0] green_duty;
    logic [7:0] red_duty;
    logic       duty_valid;
  } out_item_t;

endpackage

/* sv/psseq_cfg.sv */
// Configuration register file of the power state sequencer.
// Depends on psseq_pkg.
module psseq_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [psseq_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output psseq_pkg::cfg_t                      cfg_o
);
  import psseq_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_sleep_duty   <= MAX_SLEEP_DUTY_RST;
      cfg_q.floor_duty       <= FLOOR_DUTY_RST;
      cfg_q.feedback_hold_ms <= FEEDBACK_HOLD_MS_RST;
      cfg_q.fade_prescale    <= FADE_PRESCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_SLEEP_DUTY:   cfg_q.max_sleep_duty   <= cfg_data_i[7:0];
        CFG_FLOOR_DUTY:       cfg_q.floor_duty       <= cfg_data_i[7:0];
        CFG_FEEDBACK_HOLD_MS: cfg_q.feedback_hold_ms <= cfg_data_i[15:0];
        CFG_FADE_PRESCALE:    cfg_q.fade_prescale    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/psseq_mgmt.sv */
// Button press detection and power mode sequencing of the power state sequencer.
// Depends on psseq_pkg.
module psseq_mgmt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  psseq_pkg::in_item_t item_i,
  input  logic [15:0]         hold_ms_i,
  output psseq_pkg::mode_e    mode_o,
  output psseq_pkg::action_e  action_o,
  output psseq_pkg::mode_e    led_mode_o
);
  import psseq_pkg::*;

  mode_e       mode_q, mode_d;
  mode_e       led_mode_q, led_mode_d;
  mode_e       fb_next_q, fb_next_d;
  logic [31:0] fb_start_q, fb_start_d;
  logic        armed_q, armed_d;
  logic        pending_q, pending_d;
  logic        ind_q, ind_d;
  action_e     act;
  logic        soc_zero;
  logic [31:0] elapsed;

  assign soc_zero = (item_i.charge_percent == 7'd0);
  assign elapsed  = item_i.now_ms - fb_start_q;

  always_comb begin
    mode_d     = mode_q;
    led_mode_d = led_mode_q;
    fb_next_d  = fb_next_q;
    fb_start_d = fb_start_q;
    armed_d    = armed_q;
    pending_d  = pending_q;
    ind_d      = ind_q;
    act        = ACT_NONE;
    if (fire_i) begin
      case (kind_e'(item_i.kind))
        KIND_BUTTON: begin
          if (!item_i.button_level) begin
            armed_d = 1'b1;
          end else if (armed_q) begin
            armed_d   = 1'b0;
            pending_d = 1'b1;
          end
        end
        KIND_STEP: begin
          if (item_i.switch_off && mode_q != MODE_SHUTDOWN && mode_q != MODE_FEEDBACK) begin
            // Switching off from sleep also arms the charge indication timer.
            pending_d = 1'b0;
            if (mode_q == MODE_SLEEP) begin
              fb_start_d = item_i.now_ms;
              ind_d      = 1'b1;
              fb_next_d  = MODE_SLEEP_CHRG;
            end else begin
              ind_d = 1'b0;
            end
            mode_d     = MODE_SHUTDOWN;
            led_mode_d = MODE_SHUTDOWN;
            act        = ACT_CHRG_SLEEP;
          end else if (mode_q == MODE_SHUTDOWN && !item_i.switch_off) begin
            pending_d  = 1'b0;
            mode_d     = MODE_ACTIVE;
            led_mode_d = MODE_ACTIVE;
            ind_d      = 1'b0;
            act        = ACT_SD_WAKE;
          end else if (soc_zero && mode_q == MODE_ACTIVE && item_i.bms_ok) begin
            mode_d     = MODE_SLEEP;
            led_mode_d = MODE_SLEEP;
            act        = ACT_SLEEP;
          end else if (pending_q && mode_q == MODE_ACTIVE) begin
            pending_d = 1'b0;
            if (!item_i.charging) begin
              mode_d     = MODE_SLEEP;
              led_mode_d = MODE_SLEEP;
              act        = ACT_SLEEP;
            end else begin
              ind_d      = 1'b0;
              mode_d     = MODE_SLEEP_CHRG;
              led_mode_d = MODE_SLEEP_CHRG;
              act        = ACT_CHRG_SLEEP;
            end
          end else if (pending_q && (mode_q == MODE_SLEEP || mode_q == MODE_SLEEP_CHRG)) begin
            pending_d = 1'b0;
            if (!soc_zero || item_i.charging) begin
              mode_d     = MODE_ACTIVE;
              led_mode_d = MODE_ACTIVE;
              act        = ACT_WAKE;
            end else begin
              mode_d     = MODE_FEEDBACK;
              fb_start_d = item_i.now_ms;
              ind_d      = 1'b1;
              fb_next_d  = MODE_SLEEP;
              act        = ACT_FB_START;
            end
          end else if (mode_q == MODE_SLEEP && item_i.charging) begin
            mode_d     = MODE_FEEDBACK;
            fb_start_d = item_i.now_ms;
            ind_d      = 1'b1;
            fb_next_d  = MODE_SLEEP_CHRG;
            act        = ACT_CHRG_SLEEP;
          end else if (mode_q == MODE_SLEEP_CHRG && !item_i.charging) begin
            mode_d = MODE_SLEEP;
            act    = ACT_SLEEP;
          end else if (mode_q == MODE_FEEDBACK) begin
            if (elapsed >= {16'd0, hold_ms_i}) begin
              mode_d = fb_next_q;
              ind_d  = 1'b0;
              act    = ACT_FB_END;
            end else if (ind_q && fb_next_q == MODE_SLEEP) begin
              act = ACT_LOWBAT_IND;
            end else if (ind_q && (fb_next_q == MODE_SLEEP_CHRG ||
                                   fb_next_q == MODE_SHUTDOWN)) begin
              act = ACT_CHRG_IND;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SLEEP;
      led_mode_q <= MODE_SLEEP;
      fb_next_q  <= MODE_SLEEP;
      fb_start_q <= 32'd0;
      armed_q    <= 1'b0;
      pending_q  <= 1'b0;
      ind_q      <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      led_mode_q <= led_mode_d;
      fb_next_q  <= fb_next_d;
      fb_start_q <= fb_start_d;
      armed_q    <= armed_d;
      pending_q  <= pending_d;
      ind_q      <= ind_d;
    end
  end

  assign mode_o     = mode_d;
  assign action_o   = act;
  assign led_mode_o = led_mode_q;

endmodule

/* sv/psseq_led.sv */
// Button LED duty generation with the breathing fade of the sleep modes.
// Depends on psseq_pkg.
module psseq_led (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  psseq_pkg::mode_e led_mode_i,
  input  psseq_pkg::cfg_t  cfg_i,
  output logic [7:0]       green_o,
  output logic [7:0]       red_o,
  output logic             valid_o
);
  import psseq_pkg::*;

  logic [7:0] duty_q, duty_d;
  logic [7:0] count_q, count_d;
  logic       rising_q, rising_d;
  logic [7:0] count_inc;

  assign count_inc = count_q + 8'd1;

  always_comb begin
    duty_d   = duty_q;
    count_d  = count_q;
    rising_d = rising_q;
    green_o  = 8'd0;
    red_o    = 8'd0;
    valid_o  = 1'b0;
    if (tick_i) begin
      case (led_mode_i)
        MODE_ACTIVE: begin
          green_o = FULL_DUTY;
          red_o   = cfg_i.floor_duty;
          valid_o = 1'b1;
        end
        MODE_SLEEP, MODE_SLEEP_CHRG: begin
          if (count_inc < cfg_i.fade_prescale) begin
            count_d = count_inc;
          end else begin
            // One fade step, turning around at either limit.
            if (rising_q) begin
              if (duty_q < cfg_i.max_sleep_duty) begin
                duty_d = duty_q + 8'd1;
              end else begin
                duty_d   = cfg_i.max_sleep_duty;
                rising_d = 1'b0;
              end
            end else begin
              if (duty_q > cfg_i.floor_duty) begin
                duty_d = duty_q - 8'd1;
              end else begin
                duty_d   = cfg_i.floor_duty;
                rising_d = 1'b1;
              end
            end
            count_d = 8'd0;
            green_o = cfg_i.floor_duty;
            red_o   = duty_d;
            valid_o = 1'b1;
          end
        end
        MODE_SHUTDOWN: begin
          green_o = cfg_i.floor_duty;
          red_o   = cfg_i.floor_duty;
          valid_o = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q   <= MAX_SLEEP_DUTY_RST;
      count_q  <= 8'd0;
      rising_q <= 1'b0;
    end else begin
      duty_q   <= duty_d;
      count_q  <= count_d;
      rising_q <= rising_d;
    end
  end

endmodule

/* sv/power_state_sequencer_unit.sv */
// Top level of the power state sequencer: input register, sequencing and LED
// logic, result register. Depends on psseq_pkg, psseq_cfg, psseq_mgmt and psseq_led.

// The block takes one item per clock cycle unless the consumer stalls, and returns
// exactly one result item for each: the item is captured in an input register,
// all of its work (button edge detection, one management step or one LED tick) is
// done by short logic while it waits there, and the result lands in an output
// register, from which it is offered. The mode, LED and fade state is updated in
// the same cycle the result is registered, so the next item already sees it. When
// the consumer stalls, the finished result waits in the output register while one
// more item is still taken into the input register. Configuration writes are
// always accepted and take effect on the next cycle; they are meant to be made
// while no item is in flight. After reset the block is in sleep mode with the red
// LED fading from a duty of 100.
module power_state_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  psseq_pkg::in_item_t                in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output psseq_pkg::out_item_t               out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [psseq_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import psseq_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  logic      fire;
  logic      tick;
  cfg_t      cfg;
  mode_e     mode;
  action_e   action;
  mode_e     led_mode;
  logic [7:0] green;
  logic [7:0] red;
  logic       duty_valid;
  out_item_t  result;

  // The result register frees up when empty or when its item is taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;
  assign tick       = fire && (kind_e'(in_item_q.kind) == KIND_TICK);

  psseq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  psseq_mgmt u_mgmt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_item_q),
    .hold_ms_i  (cfg.feedback_hold_ms),
    .mode_o     (mode),
    .action_o   (action),
    .led_mode_o (led_mode)
  );

  psseq_led u_led (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .led_mode_i (led_mode),
    .cfg_i      (cfg),
    .green_o    (green),
    .red_o      (red),
    .valid_o    (duty_valid)
  );

  always_comb begin
    result.power_mode = mode;
    result.action     = action;
    result.green_duty = green;
    result.red_duty   = red;
    result.duty_valid = duty_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* tb/power_state_sequencer_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for power_state_sequencer_unit: a directed table of items,
// then random items under several register settings. Depends on psseq_pkg and power_state_sequencer_unit.
module power_state_sequencer_unit_tb;
  import psseq_pkg::*;

  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned ITEMS_PER_PHASE = 115;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  // The item kind that the block ignores.
  localparam logic [1:0]  KIND_UNUSED     = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MAX_SLEEP_DUTY;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  power_state_sequencer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted sequencer state, starting from the reset state.
  cfg_t        seq_cfg = {MAX_SLEEP_DUTY_RST, FLOOR_DUTY_RST, FEEDBACK_HOLD_MS_RST,
                          FADE_PRESCALE_RST};
  mode_e       seq_mode = MODE_SLEEP;
  mode_e       seq_led_mode = MODE_SLEEP;
  mode_e       seq_fb_next = MODE_SLEEP;
  bit          seq_armed = 1'b0;
  bit          seq_press = 1'b0;
  bit          seq_ind_on = 1'b0;
  bit          seq_fade_up = 1'b0;
  logic [31:0] seq_fb_start = '0;
  logic [7:0]  seq_fade_duty = MAX_SLEEP_DUTY_RST;
  logic [7:0]  seq_fade_count = '0;

  // Status items still owed by the block, oldest first.
  out_item_t   due_status [$];
  out_item_t   status_want;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          burst_mode = 1'b0;
  logic [31:0] clock_ms = '0;
  int unsigned sink_left = 0;
  int unsigned sink_stall;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } row_t;
  row_t plan [$];

  function automatic void enter_feedback(input mode_e next, input logic [31:0] now);
    seq_mode = MODE_FEEDBACK;
    seq_fb_start = now;
    seq_ind_on = 1'b1;
    seq_fb_next = next;
  endfunction

  function automatic void enter_charge_sleep(input mode_e from, input logic [31:0] now);
    if (from == MODE_SLEEP) begin
      enter_feedback(MODE_SLEEP_CHRG, now);
    end else if (from == MODE_SHUTDOWN) begin
      enter_feedback(MODE_SHUTDOWN, now);
    end else if (from == MODE_SLEEP_CHRG || from == MODE_ACTIVE) begin
      seq_ind_on = 1'b0;
    end
  endfunction

  // Applies one item to the predicted state and returns the status it produces.
  function automatic out_item_t sequence_step(input in_item_t it);
    out_item_t   res;
    action_e     act;
    logic        soc_zero;
    logic [31:0] elapsed;
    res = '0;
    act = ACT_NONE;
    soc_zero = (it.charge_percent == 0);
    elapsed = it.now_ms - seq_fb_start;
    case (it.kind)
      KIND_BUTTON: begin
        // A press is a low sample followed by a high one.
        if (!it.button_level) begin
          seq_armed = 1'b1;
        end else if (seq_armed) begin
          seq_armed = 1'b0;
          seq_press = 1'b1;
        end
      end
      KIND_STEP: begin
        // Switching off from a running mode goes to shutdown charge first; the rest
        // of the rules are exclusive and the first that matches wins.
        if (it.switch_off && seq_mode != MODE_SHUTDOWN && seq_mode != MODE_FEEDBACK) begin
          seq_press = 1'b0;
          enter_charge_sleep(seq_mode, it.now_ms);
          seq_mode = MODE_SHUTDOWN;
          seq_led_mode = MODE_SHUTDOWN;
          act = ACT_CHRG_SLEEP;
        end
        if (seq_mode == MODE_SHUTDOWN && !it.switch_off) begin
          seq_press = 1'b0;
          seq_mode = MODE_ACTIVE;
          seq_led_mode = MODE_ACTIVE;
          seq_ind_on = 1'b0;
          act = ACT_SD_WAKE;
        end else if (soc_zero && seq_mode == MODE_ACTIVE && it.bms_ok) begin
          seq_mode = MODE_SLEEP;
          seq_led_mode = MODE_SLEEP;
          act = ACT_SLEEP;
        end else if (seq_press && seq_mode == MODE_ACTIVE) begin
          seq_press = 1'b0;
          if (!it.charging) begin
            seq_mode = MODE_SLEEP;
            seq_led_mode = MODE_SLEEP;
            act = ACT_SLEEP;
          end else begin
            enter_charge_sleep(MODE_ACTIVE, it.now_ms);
            seq_mode = MODE_SLEEP_CHRG;
            seq_led_mode = MODE_SLEEP_CHRG;
            act = ACT_CHRG_SLEEP;
          end
        end else if (seq_press && (seq_mode == MODE_SLEEP || seq_mode == MODE_SLEEP_CHRG)) begin
          seq_press = 1'b0;
          if (!soc_zero || it.charging) begin
            seq_mode = MODE_ACTIVE;
            seq_led_mode = MODE_ACTIVE;
            act = ACT_WAKE;
          end else begin
            // An empty battery refuses to wake and shows a timed warning instead.
            enter_feedback(MODE_SLEEP, it.now_ms);
            act = ACT_FB_START;
          end
        end else if (seq_mode == MODE_SLEEP && it.charging) begin
          enter_charge_sleep(MODE_SLEEP, it.now_ms);
          act = ACT_CHRG_SLEEP;
        end else if (seq_mode == MODE_SLEEP_CHRG && !it.charging) begin
          seq_mode = MODE_SLEEP;
          act = ACT_SLEEP;
        end else if (seq_mode == MODE_FEEDBACK) begin
          // The hold is measured modulo 2^32 so the millisecond wrap is harmless.
          if (elapsed >= {16'd0, seq_cfg.feedback_hold_ms}) begin
            seq_mode = seq_fb_next;
            seq_ind_on = 1'b0;
            act = ACT_FB_END;
          end else if (seq_ind_on && seq_fb_next == MODE_SLEEP) begin
            act = ACT_LOWBAT_IND;
          end else if (seq_ind_on) begin
            act = ACT_CHRG_IND;
          end
        end
      end
      KIND_TICK: begin
        if (seq_led_mode == MODE_ACTIVE) begin
          res.green_duty = FULL_DUTY;
          res.red_duty = seq_cfg.floor_duty;
          res.duty_valid = 1'b1;
        end else if (seq_led_mode == MODE_SLEEP || seq_led_mode == MODE_SLEEP_CHRG) begin
          // Breathing fade: one duty step every fade_prescale ticks. The limits are
          // compared as given, even when the floor lies above the maximum.
          seq_fade_count = seq_fade_count + 8'd1;
          if (seq_fade_count >= seq_cfg.fade_prescale) begin
            if (seq_fade_up) begin
              if (seq_fade_duty < seq_cfg.max_sleep_duty) begin
                seq_fade_duty = seq_fade_duty + 8'd1;
              end else begin
                seq_fade_duty = seq_cfg.max_sleep_duty;
                seq_fade_up = 1'b0;
              end
            end else begin
              if (seq_fade_duty > seq_cfg.floor_duty) begin
                seq_fade_duty = seq_fade_duty - 8'd1;
              end else begin
                seq_fade_duty = seq_cfg.floor_duty;
                seq_fade_up = 1'b1;
              end
            end
            seq_fade_count = '0;
            res.green_duty = seq_cfg.floor_duty;
            res.red_duty = seq_fade_duty;
            res.duty_valid = 1'b1;
          end
        end else if (seq_led_mode == MODE_SHUTDOWN) begin
          res.green_duty = seq_cfg.floor_duty;
          res.red_duty = seq_cfg.floor_duty;
          res.duty_valid = 1'b1;
        end
      end
      default: begin
        // The unused kind leaves every piece of state alone.
      end
    endcase
    res.power_mode = seq_mode;
    res.action = act;
    return res;
  endfunction

  function automatic void plan_row(input int unsigned kind, input int unsigned lvl,
                                   input int unsigned sw, input int unsigned pct,
                                   input int unsigned chg, input int unsigned bms,
                                   input logic [31:0] now, input int unsigned typed,
                                   input mode_e m, input action_e a, input int unsigned g,
                                   input int unsigned r, input int unsigned v);
    row_t row;
    row.stim = {2'(kind), 1'(lvl), 1'(sw), 7'(pct), 1'(chg), 1'(bms), now};
    row.typed = (typed != 0);
    row.want = {m, a, 8'(g), 8'(r), 1'(v)};
    plan.push_back(row);
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.kind = KIND_TICK;
    it.button_level = 1'($urandom_range(0, 1));
    it.switch_off = 1'($urandom_range(0, 1));
    it.charge_percent = 7'($urandom_range(0, 100));
    it.charging = 1'($urandom_range(0, 1));
    it.bms_ok = 1'($urandom_range(0, 1));
    it.now_ms = $urandom;
    return it;
  endfunction

  // Offers one item, waits for it to be taken and records the status it is owed.
  // A typed row supplies its own expectation; the predictor still tracks it.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   pred;
    gap = burst_mode ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pred = sequence_step(it);
    due_status.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgDataWidth-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Registers change only with nothing in flight.
  task automatic load_settings(input cfg_t c);
    in_valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_MAX_SLEEP_DUTY, {8'd0, c.max_sleep_duty});
    write_reg(CFG_FLOOR_DUTY, {8'd0, c.floor_duty});
    write_reg(CFG_FEEDBACK_HOLD_MS, c.feedback_hold_ms);
    write_reg(CFG_FADE_PRESCALE, {8'd0, c.fade_prescale});
    cfg_valid <= 1'b0;
    seq_cfg = c;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // The sink alternates ready stretches and stalls of random length, with an
  // occasional long stretch of steady ready.
  always @(posedge clk_i) begin
    if (sink_left != 0) begin
      sink_left--;
    end else if (out_ready) begin
      sink_stall = idle_len();
      if (sink_stall != 0) begin
        out_ready <= 1'b0;
        sink_left = sink_stall - 1;
      end else begin
        sink_left = $urandom_range(0, 30);
      end
    end else begin
      out_ready <= 1'b1;
      sink_left = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(0, 15);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (due_status.size() == 0) begin
        fail_count++;
        $display("%0t: status item expected none, got %h", $time, out_item);
      end else begin
        status_want = due_status.pop_front();
        check_field("power_mode", 8'(status_want.power_mode), 8'(out_item.power_mode));
        check_field("action", 8'(status_want.action), 8'(out_item.action));
        check_field("green_duty", status_want.green_duty, out_item.green_duty);
        check_field("red_duty", status_want.red_duty, out_item.red_duty);
        check_field("duty_valid", 8'(status_want.duty_valid), 8'(out_item.duty_valid));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d status items outstanding", $time, due_status.size());
      $display("power_state_sequencer_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    cfg_t        phase_cfg [5];
    in_item_t    it;
    int unsigned sent;
    int unsigned pick;
    // Directed walk from reset. Columns: kind, button level, switch off, charge,
    // charging, bms ok, time; then whether the status is typed in and its value.
    plan_row(KIND_UNUSED, 1, 1, 100, 1, 1, 32'hFFFF_FFFF, 1, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    plan_row(KIND_STEP,   0, 0, 50,  0, 1, 32'h0,         1, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    plan_row(KIND_TICK,   1, 1, 100, 1, 1, 32'hFFFF_FFFF, 1, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    plan_row(KIND_BUTTON, 0, 0, 0,   0, 0, 32'h0,         1, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    plan_row(KIND_BUTTON, 1, 0, 0,   0, 0, 32'h0,         1, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    // The press wakes the robot since the battery is not empty.
    plan_row(KIND_STEP,   0, 0, 100, 0, 1, 10,     1, MODE_ACTIVE, ACT_WAKE, 0, 0, 0);
    plan_row(KIND_TICK,   0, 0, 0,   0, 0, 0,      1, MODE_ACTIVE, ACT_NONE, 255, 5, 1);
    // Empty battery with valid readings drops to sleep.
    plan_row(KIND_STEP,   0, 0, 0,   0, 1, 20,     1, MODE_SLEEP, ACT_SLEEP, 0, 0, 0);
    // Charging in sleep starts the charge feedback, which ends after the hold.
    plan_row(KIND_STEP,   0, 0, 100, 1, 1, 1000,   1, MODE_FEEDBACK, ACT_CHRG_SLEEP, 0, 0, 0);
    plan_row(KIND_STEP,   0, 0, 100, 1, 1, 1001,   1, MODE_FEEDBACK, ACT_CHRG_IND, 0, 0, 0);
    plan_row(KIND_TICK,   1, 0, 30,  0, 1, 7,      0, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    plan_row(KIND_STEP,   0, 0, 100, 1, 1, 4000,   1, MODE_SLEEP_CHRG, ACT_FB_END, 0, 0, 0);
    plan_row(KIND_STEP,   0, 0, 100, 0, 1, 4001,   1, MODE_SLEEP, ACT_SLEEP, 0, 0, 0);
    // Switch off from sleep: shutdown charge, with the LEDs at the floor.
    plan_row(KIND_STEP,   0, 1, 100, 0, 1, 4002,   1, MODE_SHUTDOWN, ACT_CHRG_SLEEP, 0, 0, 0);
    plan_row(KIND_TICK,   0, 0, 0,   0, 0, 0,      1, MODE_SHUTDOWN, ACT_NONE, 5, 5, 1);
    plan_row(KIND_STEP,   0, 0, 100, 0, 1, 4003,   1, MODE_ACTIVE, ACT_SD_WAKE, 0, 0, 0);
    // Press while active and not charging; the empty battery is ignored without BMS.
    plan_row(KIND_BUTTON, 0, 1, 0,   1, 1, 0,      1, MODE_ACTIVE, ACT_NONE, 0, 0, 0);
    plan_row(KIND_BUTTON, 1, 1, 0,   1, 1, 0,      1, MODE_ACTIVE, ACT_NONE, 0, 0, 0);
    plan_row(KIND_STEP,   0, 0, 0,   0, 0, 4004,   1, MODE_SLEEP, ACT_SLEEP, 0, 0, 0);
    // Press in sleep with an empty battery: low battery warning across the time wrap.
    plan_row(KIND_BUTTON, 0, 0, 0,   0, 0, 0,      1, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    plan_row(KIND_BUTTON, 1, 0, 0,   0, 0, 0,      1, MODE_SLEEP, ACT_NONE, 0, 0, 0);
    plan_row(KIND_STEP,   0, 0, 0,   0, 1, 32'hFFFF_FF00, 1, MODE_FEEDBACK, ACT_FB_START,
             0, 0, 0);
    plan_row(KIND_STEP,   0, 1, 100, 1, 1, 32'hFFFF_FF01, 1, MODE_FEEDBACK, ACT_LOWBAT_IND,
             0, 0, 0);
    plan_row(KIND_STEP,   0, 0, 100, 0, 1, 32'h0000_0F00, 1, MODE_SLEEP, ACT_FB_END, 0, 0, 0);
    plan_row(KIND_TICK,   1, 1, 100, 1, 1, 32'hFFFF_FFFF, 0, MODE_SLEEP, ACT_NONE, 0, 0, 0);

    // Settings: extremes, crossed fade limits, prescale zero, a random one, reset values.
    phase_cfg[0] = {8'd255, 8'd0, 16'd0, 8'd255};
    phase_cfg[1] = {8'd5, 8'd255, 16'd65535, 8'd1};
    phase_cfg[2] = {8'd12, 8'd3, 16'd40, 8'd0};
    phase_cfg[3].max_sleep_duty = 8'($urandom_range(5, 255));
    phase_cfg[3].floor_duty = 8'($urandom_range(0, 255));
    phase_cfg[3].feedback_hold_ms = 16'($urandom_range(0, 200));
    phase_cfg[3].fade_prescale = 8'($urandom_range(1, 4));
    phase_cfg[4] = {MAX_SLEEP_DUTY_RST, FLOOR_DUTY_RST, FEEDBACK_HOLD_MS_RST,
                    FADE_PRESCALE_RST};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_item(plan[i].stim, plan[i].typed, plan[i].want);

    foreach (phase_cfg[p]) begin
      load_settings(phase_cfg[p]);
      // One phase runs with the sender never idling.
      burst_mode = (p == 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        it = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          send_item(it, 1'b0, '0);
          sent++;
        end else if (pick < 62) begin
          // Time moves on mostly in small steps, sometimes past the hold, rarely anywhere.
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            clock_ms = clock_ms + $urandom_range(0, 20);
          end else if (pick < 9) begin
            clock_ms = clock_ms + $urandom_range(0, 2 * seq_cfg.feedback_hold_ms + 2);
          end else begin
            clock_ms = $urandom;
          end
          it.kind = KIND_STEP;
          it.switch_off = ($urandom_range(0, 9) == 0);
          it.charge_percent = ($urandom_range(0, 4) == 0) ? 7'd0 : 7'($urandom_range(1, 100));
          it.bms_ok = ($urandom_range(0, 4) != 0);
          it.now_ms = clock_ms;
          send_item(it, 1'b0, '0);
          sent++;
        end else if (pick < 92) begin
          // A full press: low sample, then high sample.
          it.kind = KIND_BUTTON;
          it.button_level = 1'b0;
          send_item(it, 1'b0, '0);
          it = random_fields();
          it.kind = KIND_BUTTON;
          it.button_level = 1'b1;
          send_item(it, 1'b0, '0);
          sent += 2;
        end else if (pick < 97) begin
          it.kind = KIND_BUTTON;
          send_item(it, 1'b0, '0);
          sent++;
        end else begin
          it.kind = KIND_UNUSED;
          send_item(it, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("power_state_sequencer_unit_tb: clean");
    end else begin
      $display("power_state_sequencer_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/psseq_pkg.sv
sv/psseq_cfg.sv
sv/psseq_mgmt.sv
sv/psseq_led.sv
sv/power_state_sequencer_unit.sv
tb/power_state_sequencer_unit_tb.sv
